// ===== rtl/byte_ring_buffer_fifo_top_macros.svh =====
// Assertion macros shared by the byte ring buffer FIFO checker.
`ifndef BYTE_RING_BUFFER_FIFO_TOP_MACROS_SVH
`define BYTE_RING_BUFFER_FIFO_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define BRBF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brbf assertion failed in same cycle");

// Check a consequent in the cycle after its antecedent.
`define BRBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brbf assertion failed in next cycle");

`endif

// ===== rtl/brbf_pkg.sv =====
// Types and constants shared by the byte ring buffer FIFO modules.
package brbf_pkg;

   // field widths
   localparam int CFG_W     = 4;
   localparam int BYTE_W    = 8;
   localparam int REQ_W     = 7;
   localparam int CMD_W     = 2;
   localparam int FILL_W    = 11;
   localparam int SAT_W     = 5;

   localparam logic [CFG_W-1:0] CAP_LOG2_RESET = 4'd10;

   // stream packing
   localparam int REQ_TDATA_W   = 16;
   localparam int REQ_COUNT_LSB = 8;
   localparam int RSP_TDATA_W   = 40;
   localparam int RSP_PUT_BIT   = 8;
   localparam int RSP_FILL_LSB  = 9;
   localparam int RSP_SPACE_LSB = 20;
   localparam int RSP_EMPTY_BIT = 31;
   localparam int RSP_FULL_BIT  = 32;
   localparam int RSP_PAD_W     = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT    = 2'd0,
      CMD_GET    = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_STATUS = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_BURST = 2'b10
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic put_en;
      logic clear_en;
      logic get_start;
      logic rd_step;
      logic load_status;
      logic load_byte;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic get_none;
      logic rem_zero;
   } dp_stat_type;

endpackage

// ===== rtl/byte_ring_buffer_fifo_top.sv =====
// Top level of the byte ring buffer FIFO: stream ports, controller and datapath.
// Put, clear, status and empty get: result shown in the cycle after the transfer in.
// Get burst: each byte passes the registered read port of the byte store, then the result
// register; one byte a cycle while the receiver takes them; next item taken after the last.
// Reset clears counts, capacity (to 1024) and result valid; the store is not cleared.
module byte_ring_buffer_fifo_top import brbf_pkg::*; #(
   parameter int DEPTH     = 1024,
   parameter int MAX_BURST = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CFG_W-1:0]       csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // data_in[7:0], request_count[14:8], zero pad [15]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // command[1:0]
   input  logic [CMD_W-1:0]       req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // read_byte[7:0], put_accepted[8], fill_level[19:9], space_left[30:20],
   // empty_flag[31], full_flag[32], zero pad [39:33]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // byte_valid[0]
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);

   dp_cmd_type        cmd;
   dp_stat_type       stat;
   logic [BYTE_W-1:0] read_byte;
   logic              put_accepted;
   logic [FILL_W-1:0] fill_level;
   logic [FILL_W-1:0] space_left;
   logic              empty_flag;
   logic              full_flag;

   brbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .command   (cmd_type'(req_tuser)),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   brbf_dpath #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .data_in       (req_tdata[BYTE_W-1:0]),
      .request_count (req_tdata[REQ_COUNT_LSB +: REQ_W]),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .read_byte     (read_byte),
      .byte_valid    (rsp_tuser),
      .last          (rsp_tlast),
      .put_accepted  (put_accepted),
      .fill_level    (fill_level),
      .space_left    (space_left),
      .empty_flag    (empty_flag),
      .full_flag     (full_flag)
   );

   // pack result fields, highest first
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, full_flag, empty_flag, space_left,
                       fill_level, put_accepted, read_byte};

endmodule

// ===== rtl/brbf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module brbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, held between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/brbf_ctrl.sv =====
// Controller state machine for the byte ring buffer FIFO.
module brbf_ctrl import brbf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  cmd_type     command,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;

   // decode commands and sequence get bursts
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               unique case (command)
                  CMD_PUT: begin
                     cmd.put_en      = 1'b1;
                     cmd.load_status = 1'b1;
                  end
                  CMD_GET: begin
                     if (stat.get_none) begin
                        cmd.load_status = 1'b1;
                     end else begin
                        cmd.get_start = 1'b1;
                        state_in      = ST_BURST;
                     end
                  end
                  CMD_CLEAR: begin
                     cmd.clear_en    = 1'b1;
                     cmd.load_status = 1'b1;
                  end
                  CMD_STATUS: begin
                     cmd.load_status = 1'b1;
                  end
                  default: begin
                     cmd.load_status = 1'b1;
                  end
               endcase
            end
         end
         ST_BURST: begin
            // hand the fetched byte on and, while bytes remain, fetch the next one
            if (stat.out_free) begin
               cmd.load_byte = 1'b1;
               if (stat.rem_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_step = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/brbf_dpath.sv =====
// Datapath: counts, capacity register, byte store and result register.
module brbf_dpath import brbf_pkg::*; #(
   parameter int DEPTH     = 1024,
   parameter int MAX_BURST = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wen,
   input  logic [CFG_W-1:0]  csr_wdata,
   input  logic [BYTE_W-1:0] data_in,
   input  logic [REQ_W-1:0]  request_count,
   input  dp_cmd_type        cmd,
   output dp_stat_type       stat,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [BYTE_W-1:0] read_byte,
   output logic              byte_valid,
   output logic              last,
   output logic              put_accepted,
   output logic [FILL_W-1:0] fill_level,
   output logic [FILL_W-1:0] space_left,
   output logic              empty_flag,
   output logic              full_flag
);

   localparam int MAX_LOG = $clog2(DEPTH + 1) - 1;
   localparam int CW      = MAX_LOG + 1;
   localparam int AW      = $clog2(DEPTH);
   localparam int CMP_W   = (CW > REQ_W) ? CW : REQ_W;

   logic [CFG_W-1:0]  cap_log2_ff, cap_log2_in;
   logic [CW-1:0]     wr_count_ff, wr_count_in;
   logic [CW-1:0]     rd_count_ff, rd_count_in;
   logic [REQ_W-1:0]  rem_ff, rem_in;

   logic [SAT_W-1:0]  k_sat;
   logic [CW-1:0]     cap;
   logic [CW-1:0]     mask;
   logic [CW-1:0]     fill;
   logic              put_ok;
   logic [CW-1:0]     wr_masked;
   logic [CW-1:0]     rd_masked;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic              rd_en;
   logic [BYTE_W-1:0] ram_rdata;
   logic [REQ_W-1:0]  req_clamp;
   logic [CMP_W-1:0]  fill_ext;
   logic [CMP_W-1:0]  req_ext;
   logic [REQ_W-1:0]  burst_len;
   logic [CW-1:0]     report_fill;
   logic              load;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] read_byte_ff;
   logic              byte_valid_ff;
   logic              last_ff;
   logic              put_acc_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] space_ff;
   logic              empty_ff;
   logic              full_ff;

   // saturate capacity and derive ring mask
   assign k_sat  = ({1'b0, cap_log2_ff} > SAT_W'(MAX_LOG)) ? SAT_W'(MAX_LOG)
                                                             : {1'b0, cap_log2_ff};
   assign cap    = CW'(1) << k_sat;
   assign mask   = cap - CW'(1);
   assign fill   = wr_count_ff - rd_count_ff;
   assign put_ok = fill < cap;

   // ring addresses
   assign wr_masked = wr_count_ff & mask;
   assign rd_masked = rd_count_ff & mask;
   assign wr_addr   = wr_masked[AW-1:0];
   assign rd_addr   = rd_masked[AW-1:0];
   assign rd_en     = cmd.get_start | cmd.rd_step;

   brbf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.put_en & put_ok),
      .wr_addr (wr_addr),
      .wr_data (data_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // clamp burst to limit and fill
   assign req_clamp = (request_count > REQ_W'(MAX_BURST)) ? REQ_W'(MAX_BURST)
                                                            : request_count;
   assign fill_ext  = CMP_W'(fill);
   assign req_ext   = CMP_W'(req_clamp);
   assign burst_len = (fill_ext < req_ext) ? fill_ext[REQ_W-1:0] : req_clamp;

   assign load          = cmd.load_status | cmd.load_byte;
   assign stat.out_free = ~valid_ff | rsp_ready;
   assign stat.get_none = (burst_len == '0);
   assign stat.rem_zero = (rem_ff == '0);

   // advance counts
   always_comb begin
      cap_log2_in = cap_log2_ff;
      wr_count_in = wr_count_ff;
      rd_count_in = rd_count_ff;
      rem_in      = rem_ff;
      if (csr_wen) begin
         cap_log2_in = csr_wdata;
      end
      if (cmd.clear_en) begin
         wr_count_in = '0;
         rd_count_in = '0;
      end else begin
         if (cmd.put_en && put_ok) begin
            wr_count_in = wr_count_ff + CW'(1);
         end
         if (rd_en) begin
            rd_count_in = rd_count_ff + CW'(1);
         end
      end
      if (cmd.get_start) begin
         rem_in = burst_len - REQ_W'(1);
      end else if (cmd.rd_step) begin
         rem_in = rem_ff - REQ_W'(1);
      end
   end

   // fill as it stands after this result's update
   always_comb begin
      if (cmd.clear_en) begin
         report_fill = '0;
      end else if (cmd.put_en && put_ok) begin
         report_fill = fill + CW'(1);
      end else begin
         report_fill = fill;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_log2_ff <= CAP_LOG2_RESET;
         wr_count_ff <= '0;
         rd_count_ff <= '0;
         rem_ff      <= '0;
      end else begin
         cap_log2_ff <= cap_log2_in;
         wr_count_ff <= wr_count_in;
         rd_count_ff <= rd_count_in;
         rem_ff      <= rem_in;
      end
   end

   // result register: hold until the transfer completes
   assign valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         read_byte_ff  <= cmd.load_byte ? ram_rdata : '0;
         byte_valid_ff <= cmd.load_byte;
         last_ff       <= cmd.load_byte ? stat.rem_zero : 1'b1;
         put_acc_ff    <= cmd.load_status & cmd.put_en & put_ok;
         fill_ff       <= FILL_W'(report_fill);
         space_ff      <= (report_fill >= cap) ? '0 : FILL_W'(cap - report_fill);
         empty_ff      <= (report_fill == '0);
         full_ff       <= (report_fill >= cap);
      end
   end

   assign rsp_valid    = valid_ff;
   assign read_byte    = read_byte_ff;
   assign byte_valid   = byte_valid_ff;
   assign last         = last_ff;
   assign put_accepted = put_acc_ff;
   assign fill_level   = fill_ff;
   assign space_left   = space_ff;
   assign empty_flag   = empty_ff;
   assign full_flag    = full_ff;

endmodule

// ===== rtl/brbf_checker.sv =====
// Port-level checker for the byte ring buffer FIFO, bound to the top level.
`include "byte_ring_buffer_fifo_top_macros.svh"

module brbf_checker import brbf_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser,
   input logic                   rsp_tlast
);

   // a stalled result holds
   `BRBF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // a result without a byte always ends its item
   `BRBF_ASSERT_SAME(a_nobyte_last, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast)

   // a full ring reports no free space
   `BRBF_ASSERT_SAME(a_full_space, clock, reset, rsp_tvalid && rsp_tdata[RSP_FULL_BIT], rsp_tdata[RSP_SPACE_LSB +: FILL_W] == '0)

   // a stored put carries no read byte
   `BRBF_ASSERT_SAME(a_put_nobyte, clock, reset, rsp_tvalid && rsp_tdata[RSP_PUT_BIT], !rsp_tuser && rsp_tdata[BYTE_W-1:0] == '0)

endmodule

bind byte_ring_buffer_fifo_top brbf_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/byte_ring_buffer_fifo_top_tb.sv =====
// Self-checking testbench for the byte ring buffer FIFO stream top level.
`timescale 1ns / 100ps

module byte_ring_buffer_fifo_top_tb;
   import brbf_pkg::*;

   localparam int RING_DEPTH   = 1024;
   localparam int BURST_LIMIT  = 64;
   localparam int LOG2_LIMIT   = 10;
   localparam int STALL_LIMIT  = 2000;
   localparam int LATENCY_TAIL = 10;
   localparam int PHASE_COUNT  = 6;
   localparam int PHASE_ITEMS  = 12;
   localparam int HOLD_CYCLES  = 300;
   localparam int PRESSURE_RUN = 40;
   // capacity setting per random phase, phase 0 in the low nibble
   localparam logic [PHASE_COUNT*CFG_W-1:0] PHASE_CAPS = {4'd0, 4'd1, 4'd10, 4'd15, 4'd0, 4'd3};

   typedef struct packed {
      logic [BYTE_W-1:0] rd_byte;
      logic              byte_ok;
      logic              last;
      logic              put_ok;
      logic [FILL_W-1:0] fill;
      logic [FILL_W-1:0] space;
      logic              empty;
      logic              full;
   } fifo_result_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [CFG_W-1:0]  csr_value;
      cmd_type           cmd;
      logic [BYTE_W-1:0] data;
      logic [REQ_W-1:0]  count;
      logic              typed;
      fifo_result_type   typed_res;
   } row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wen;
   logic [CFG_W-1:0]       csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]       req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   // predictor state: shadow ring, free-running counts, capacity register
   logic [BYTE_W-1:0] ring_copy [RING_DEPTH];
   bit                byte_written [RING_DEPTH];
   logic [16:0]       wr_count = '0;
   logic [16:0]       rd_count = '0;
   logic [CFG_W-1:0]  cap_log2 = CAP_LOG2_RESET;

   fifo_result_type pending_fifo_results[$];
   fifo_result_type step_results[$];
   row_type         directed_rows[$];

   int errors = 0;
   int items_sent = 0;
   int stall_left = 0;
   int rsp_hold_request = 0;
   bit sender_calm = 1'b0;
   bit receiver_calm = 1'b0;

   byte_ring_buffer_fifo_top #(
      .DEPTH     (RING_DEPTH),
      .MAX_BURST (BURST_LIMIT)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned ring_size();
      return (cap_log2 > LOG2_LIMIT) ? RING_DEPTH : (1 << cap_log2);
   endfunction

   function automatic int unsigned ring_fill();
      return (wr_count - rd_count) & 32'h1FFFF;
   endfunction

   // status fields as they stand after the current update
   function automatic fifo_result_type level_result(logic [BYTE_W-1:0] b, logic v, logic l,
                                                    logic a);
      fifo_result_type r;
      int unsigned f;
      int unsigned cap;
      f = ring_fill();
      cap = ring_size();
      r.rd_byte = b;
      r.byte_ok = v;
      r.last    = l;
      r.put_ok  = a;
      r.fill    = FILL_W'(f);
      r.space   = (f >= cap) ? '0 : FILL_W'(cap - f);
      r.empty   = (f == 0);
      r.full    = (f >= cap);
      return r;
   endfunction

   // compute the results of one command and advance the shadow state
   function automatic void predict_ring_results(cmd_type c, logic [BYTE_W-1:0] d,
                                                logic [REQ_W-1:0] n);
      int unsigned cap;
      int unsigned moves;
      int unsigned idx;
      int unsigned i;
      logic        stored;
      cap = ring_size();
      stored = 1'b0;
      step_results.delete();
      case (c)
         CMD_PUT: begin
            if (ring_fill() < cap) begin
               idx = wr_count & (cap - 1);
               ring_copy[idx] = d;
               byte_written[idx] = 1'b1;
               wr_count = wr_count + 17'd1;
               stored = 1'b1;
            end
            step_results.push_back(level_result('0, 1'b0, 1'b1, stored));
         end
         CMD_GET: begin
            moves = n;
            if (moves > BURST_LIMIT) moves = BURST_LIMIT;
            if (moves > ring_fill()) moves = ring_fill();
            if (moves == 0) begin
               step_results.push_back(level_result('0, 1'b0, 1'b1, 1'b0));
            end
            for (i = 0; i < moves; i++) begin
               idx = rd_count & (cap - 1);
               rd_count = rd_count + 17'd1;
               step_results.push_back(level_result(ring_copy[idx], 1'b1, i + 1 == moves,
                                                   1'b0));
            end
         end
         CMD_CLEAR: begin
            wr_count = '0;
            rd_count = '0;
            step_results.push_back(level_result('0, 1'b0, 1'b1, 1'b0));
         end
         default: begin
            step_results.push_back(level_result('0, 1'b0, 1'b1, 1'b0));
         end
      endcase
   endfunction

   // shorten a get so that it never reads a store entry that was never written
   function automatic logic [REQ_W-1:0] readable_request(logic [REQ_W-1:0] n);
      int unsigned moves;
      int unsigned mask;
      int unsigned i;
      moves = n;
      if (moves > BURST_LIMIT) moves = BURST_LIMIT;
      if (moves > ring_fill()) moves = ring_fill();
      mask = ring_size() - 1;
      for (i = 0; i < moves; i++) begin
         if (!byte_written[(rd_count + i) & mask]) return REQ_W'(i);
      end
      return n;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic int idle_length();
      return ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   function automatic row_type item_row(cmd_type c, logic [BYTE_W-1:0] d,
                                        logic [REQ_W-1:0] n);
      row_type r;
      r = '0;
      r.kind  = ROW_ITEM;
      r.cmd   = c;
      r.data  = d;
      r.count = n;
      return r;
   endfunction

   function automatic row_type checked_row(cmd_type c, logic [BYTE_W-1:0] d,
                                           logic [REQ_W-1:0] n,
                                           logic acc, logic [FILL_W-1:0] f,
                                           logic [FILL_W-1:0] sp, logic e, logic fu);
      row_type r;
      r = item_row(c, d, n);
      r.typed = 1'b1;
      r.typed_res.rd_byte = '0;
      r.typed_res.byte_ok = 1'b0;
      r.typed_res.last    = 1'b1;
      r.typed_res.put_ok  = acc;
      r.typed_res.fill    = f;
      r.typed_res.space   = sp;
      r.typed_res.empty   = e;
      r.typed_res.full    = fu;
      return r;
   endfunction

   function automatic row_type csr_row(logic [CFG_W-1:0] v);
      row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.csr_value = v;
      return r;
   endfunction

   // offer one command, hold it until the transfer, then record its results
   task automatic send_item(cmd_type c, logic [BYTE_W-1:0] d, logic [REQ_W-1:0] n,
                            logic typed, fifo_result_type typed_res);
      int gap;
      logic [REQ_W-1:0] count;
      gap = 0;
      count = (c == CMD_GET) ? readable_request(n) : n;
      if (!sender_calm && $urandom_range(99) < 40) gap = idle_length();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= {{(REQ_TDATA_W - REQ_COUNT_LSB - REQ_W){1'b0}}, count, d};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_ring_results(c, d, count);
      if (typed) begin
         pending_fifo_results.push_back(typed_res);
      end else begin
         foreach (step_results[i]) pending_fifo_results.push_back(step_results[i]);
      end
      items_sent++;
   endtask

   // drop valid and hold until every expected result has been taken
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_fifo_results.size() != 0);
   endtask

   task automatic write_capacity(logic [CFG_W-1:0] v);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
      cap_log2 = v;
   endtask

   // mostly put runs read back by a matching get, the rest single commands
   task automatic random_traffic();
      int unsigned pick;
      int unsigned run;
      logic [REQ_W-1:0] count;
      pick = $urandom_range(99);
      if (pick < 55) begin
         run = $urandom_range(1, 12);
         repeat (run) send_item(CMD_PUT, BYTE_W'($urandom), REQ_W'($urandom), 1'b0, '0);
         count = ($urandom_range(3) == 0) ? REQ_W'($urandom) : REQ_W'(run);
         send_item(CMD_GET, BYTE_W'($urandom), count, 1'b0, '0);
      end else if (pick < 70) begin
         case ($urandom_range(2))
            0: count = '0;
            1: count = REQ_W'($urandom_range(1, 8));
            default: count = REQ_W'($urandom);
         endcase
         send_item(CMD_GET, BYTE_W'($urandom), count, 1'b0, '0);
      end else if (pick < 80) begin
         send_item(CMD_PUT, BYTE_W'($urandom), REQ_W'($urandom), 1'b0, '0);
      end else if (pick < 88) begin
         send_item(CMD_STATUS, BYTE_W'($urandom), REQ_W'($urandom), 1'b0, '0);
      end else if (pick < 94) begin
         send_item(CMD_CLEAR, BYTE_W'($urandom), REQ_W'($urandom), 1'b0, '0);
      end else begin
         wait_for_results();
      end
   endtask

   // ---------------------------------------------------------------- receiver

   // take results with random stalls; a hold request stalls for that many cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_hold_request != 0) begin
            stall_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (stall_left == 0 && !receiver_calm && $urandom_range(99) < 20)
            stall_left = idle_length();
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin : result_check
      fifo_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_fifo_results.size() == 0) begin
            $error("result transfer with no expectation pending");
            errors++;
         end else begin
            want = pending_fifo_results.pop_front();
            check_field("read_byte", want.rd_byte, rsp_tdata[BYTE_W-1:0]);
            check_field("byte_valid", want.byte_ok, rsp_tuser);
            check_field("last", want.last, rsp_tlast);
            check_field("put_accepted", want.put_ok, rsp_tdata[RSP_PUT_BIT]);
            check_field("fill_level", want.fill, rsp_tdata[RSP_FILL_LSB +: FILL_W]);
            check_field("space_left", want.space, rsp_tdata[RSP_SPACE_LSB +: FILL_W]);
            check_field("empty_flag", want.empty, rsp_tdata[RSP_EMPTY_BIT]);
            check_field("full_flag", want.full, rsp_tdata[RSP_FULL_BIT]);
         end
      end
   end

   // end the run when nothing moves on either side for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("byte_ring_buffer_fifo_top_tb failed");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      int ph;
      int phase_end;
      logic [CFG_W-1:0] cap_value;

      reset      <= 1'b1;
      csr_wen    <= 1'b0;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_PUT;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table: reset state, field extremes, every command, corner cases
      directed_rows.push_back(checked_row(CMD_STATUS, 8'h00, 7'd0, 1'b0, 11'd0, 11'd1024,
                                          1'b1, 1'b0));
      // get on an empty ring
      directed_rows.push_back(checked_row(CMD_GET, 8'h00, 7'd5, 1'b0, 11'd0, 11'd1024,
                                          1'b1, 1'b0));
      directed_rows.push_back(checked_row(CMD_PUT, 8'h00, 7'd0, 1'b1, 11'd1, 11'd1023,
                                          1'b0, 1'b0));
      directed_rows.push_back(checked_row(CMD_PUT, 8'hFF, 7'd127, 1'b1, 11'd2, 11'd1022,
                                          1'b0, 1'b0));
      directed_rows.push_back(item_row(CMD_PUT, 8'hA5, 7'd0));
      // get of zero bytes
      directed_rows.push_back(checked_row(CMD_GET, 8'h00, 7'd0, 1'b0, 11'd3, 11'd1021,
                                          1'b0, 1'b0));
      // request above the burst limit and the fill
      directed_rows.push_back(item_row(CMD_GET, 8'hFF, 7'd127));
      directed_rows.push_back(checked_row(CMD_CLEAR, 8'h00, 7'd0, 1'b0, 11'd0, 11'd1024,
                                          1'b1, 1'b0));
      // one-byte ring: second put is dropped
      directed_rows.push_back(csr_row(4'd0));
      directed_rows.push_back(checked_row(CMD_PUT, 8'h5A, 7'd0, 1'b1, 11'd1, 11'd0,
                                          1'b0, 1'b1));
      directed_rows.push_back(checked_row(CMD_PUT, 8'h3C, 7'd0, 1'b0, 11'd1, 11'd0,
                                          1'b0, 1'b1));
      directed_rows.push_back(item_row(CMD_GET, 8'h00, 7'd1));
      // capacity above the largest power saturates
      directed_rows.push_back(csr_row(4'd15));
      directed_rows.push_back(checked_row(CMD_STATUS, 8'h00, 7'd0, 1'b0, 11'd0, 11'd1024,
                                          1'b1, 1'b0));
      directed_rows.push_back(item_row(CMD_PUT, 8'h01, 7'd0));
      directed_rows.push_back(item_row(CMD_PUT, 8'h02, 7'd0));
      directed_rows.push_back(item_row(CMD_PUT, 8'h04, 7'd0));
      directed_rows.push_back(item_row(CMD_PUT, 8'h08, 7'd0));
      directed_rows.push_back(item_row(CMD_PUT, 8'h10, 7'd0));
      // capacity lowered below the fill
      directed_rows.push_back(csr_row(4'd1));
      directed_rows.push_back(checked_row(CMD_STATUS, 8'h00, 7'd0, 1'b0, 11'd5, 11'd0,
                                          1'b0, 1'b1));
      directed_rows.push_back(checked_row(CMD_PUT, 8'h20, 7'd0, 1'b0, 11'd5, 11'd0,
                                          1'b0, 1'b1));
      directed_rows.push_back(item_row(CMD_GET, 8'h00, 7'd2));
      directed_rows.push_back(item_row(CMD_GET, 8'h00, 7'd64));
      directed_rows.push_back(csr_row(CAP_LOG2_RESET));
      directed_rows.push_back(item_row(CMD_PUT, 8'h40, 7'd0));
      directed_rows.push_back(item_row(CMD_PUT, 8'h80, 7'd0));
      directed_rows.push_back(item_row(CMD_GET, 8'h00, 7'd2));

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_for_results();
            write_capacity(directed_rows[i].csr_value);
         end else begin
            send_item(directed_rows[i].cmd, directed_rows[i].data, directed_rows[i].count,
                      directed_rows[i].typed, directed_rows[i].typed_res);
         end
      end

      // random phases, each under its own capacity
      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         wait_for_results();
         cap_value = PHASE_CAPS[ph*CFG_W +: CFG_W];
         if (ph == PHASE_COUNT - 1) cap_value = CFG_W'($urandom_range(15));
         write_capacity(cap_value);
         sender_calm   = (ph == 2);
         receiver_calm = (ph == 2);

         // back-pressure: receiver holds off while a long put run fills the block
         if (ph == 3) begin
            send_item(CMD_CLEAR, 8'h00, 7'd0, 1'b0, '0);
            rsp_hold_request = HOLD_CYCLES;
            sender_calm = 1'b1;
            repeat (PRESSURE_RUN)
               send_item(CMD_PUT, BYTE_W'($urandom), REQ_W'($urandom), 1'b0, '0);
            send_item(CMD_GET, 8'h00, 7'd127, 1'b0, '0);
            send_item(CMD_GET, 8'h00, 7'd64, 1'b0, '0);
            sender_calm = 1'b0;
         end

         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) random_traffic();
      end

      wait_for_results();
      repeat (LATENCY_TAIL) @(posedge clock);
      if (errors == 0 && pending_fifo_results.size() == 0) begin
         $display("byte_ring_buffer_fifo_top_tb passed");
      end else begin
         $display("byte_ring_buffer_fifo_top_tb failed");
      end
      $finish;
   end

endmodule
